### src/scsi_pkg.sv
// ----------------------------------------------------------------------------
// scsi_pkg
// shared types and constants for the sorted snap candidate list
// ----------------------------------------------------------------------------
package scsi_pkg;

  localparam int DefCapacity = 64;
  localparam int CoordW      = 24;
  localparam int DistW       = 50;
  localparam int ModeW       = 8;
  localparam int CfgIdxW     = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CURSOR_X  = 3'd0,
    REG_CURSOR_Y  = 3'd1,
    REG_BOX_MIN_X = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MIN_Y = 3'd4,
    REG_BOX_MAX_Y = 3'd5
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // one stored list entry
  typedef struct packed {
    logic [DistW-1:0]  dist_sq;
    logic [CoordW-1:0] wx;
    logic [CoordW-1:0] wy;
    logic [CoordW-1:0] wz;
    logic [ModeW-1:0]  mode;
    logic              nearest;
    logic              in_box;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // classified word handed from front to back
  typedef struct packed {
    logic   op;
    entry_t ent;
  } cmd_t;

endpackage

### src/scsi_stream_if.sv
// ----------------------------------------------------------------------------
// scsi_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface scsi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/scsi_ram.sv
// ----------------------------------------------------------------------------
// scsi_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module scsi_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/scsi_front.sv
// ----------------------------------------------------------------------------
// scsi_front
// input stage: distance, aperture test, pipelined through stages a and b across cycles
// ----------------------------------------------------------------------------
module scsi_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [scsi_pkg::ModeW-1:0]  in_mode,
  input  logic                        in_nearest,
  input  logic [scsi_pkg::CoordW-1:0] in_wx,
  input  logic [scsi_pkg::CoordW-1:0] in_wy,
  input  logic [scsi_pkg::CoordW-1:0] in_wz,
  input  logic [scsi_pkg::CoordW-1:0] in_sx,
  input  logic [scsi_pkg::CoordW-1:0] in_sy,
  input  logic signed [scsi_pkg::CoordW-1:0] cur_x,
  input  logic signed [scsi_pkg::CoordW-1:0] cur_y,
  input  logic signed [scsi_pkg::CoordW-1:0] bx0,
  input  logic signed [scsi_pkg::CoordW-1:0] bx1,
  input  logic signed [scsi_pkg::CoordW-1:0] by0,
  input  logic signed [scsi_pkg::CoordW-1:0] by1,
  output logic                        q_push,
  output scsi_pkg::cmd_t              q_data,
  input  logic                        q_space
);
  import scsi_pkg::*;

  // stage a: differences and box flag
  logic              a_vld_r;
  cmd_t              a_cmd_r;
  logic [CoordW:0]   a_dx_r, a_dy_r;
  // stage b: squares
  logic              b_vld_r;
  cmd_t              b_cmd_r;
  logic [2*CoordW-1:0] b_sqx_r, b_sqy_r;

  logic signed [CoordW:0] dx, dy;
  logic signed [CoordW-1:0] mnx, mxx, mny, mxy, sx, sy;
  logic inb;

  always_comb begin
    sx  = in_sx;
    sy  = in_sy;
    mnx = (bx0 < bx1) ? bx0 : bx1;
    mxx = (bx0 < bx1) ? bx1 : bx0;
    mny = (by0 < by1) ? by0 : by1;
    mxy = (by0 < by1) ? by1 : by0;
    inb = (sx > mnx) && (sx < mxx) && (sy > mny) && (sy < mxy);
    dx  = {sx[CoordW-1], sx} - {cur_x[CoordW-1], cur_x};
    dy  = {sy[CoordW-1], sy} - {cur_y[CoordW-1], cur_y};
  end

  // one item at a time in the pipe; accept only when nothing is in flight
  assign in_ready = !a_vld_r && !b_vld_r && q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid && in_ready;
      b_vld_r <= a_vld_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd_r.op          <= in_op;
      a_cmd_r.ent.dist_sq <= '0;
      a_cmd_r.ent.wx      <= in_wx;
      a_cmd_r.ent.wy      <= in_wy;
      a_cmd_r.ent.wz      <= in_wz;
      a_cmd_r.ent.mode    <= in_mode;
      a_cmd_r.ent.nearest <= in_nearest;
      a_cmd_r.ent.in_box  <= inb;
      a_dx_r <= dx[CoordW] ? (CoordW+1)'(0) - dx : dx;
      a_dy_r <= dy[CoordW] ? (CoordW+1)'(0) - dy : dy;
    end
    b_cmd_r <= a_cmd_r;
    b_sqx_r <= (2*CoordW)'(a_dx_r * a_dx_r);
    b_sqy_r <= (2*CoordW)'(a_dy_r * a_dy_r);
  end

  always_comb begin
    q_push        = b_vld_r;
    q_data        = b_cmd_r;
    q_data.ent.dist_sq = DistW'(b_sqx_r) + DistW'(b_sqy_r);
  end
endmodule

### src/scsi_fifo.sv
// ----------------------------------------------------------------------------
// scsi_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module scsi_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scsi_pkg::cmd_t push_data,
  output logic           space,
  output logic           pop_valid,
  input  logic           pop,
  output scsi_pkg::cmd_t pop_data
);
  import scsi_pkg::*;

  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign space     = (cnt_r == 2'd0);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_data;
  end
endmodule

### src/scsi_back.sv
// ----------------------------------------------------------------------------
// scsi_back
// list engine: clear, end tests, binary search, duplicate scan, shift and insert
// ----------------------------------------------------------------------------
module scsi_back #(
  parameter int Capacity = scsi_pkg::DefCapacity
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  scsi_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_accepted,
  output logic [1:0]     out_status,
  output logic [5:0]     out_position,
  output logic [6:0]     out_entry_count
);
  import scsi_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LAST   = 9'b000000010,
    S_FIRST  = 9'b000000100,
    S_PROBE  = 9'b000001000,
    S_BIN    = 9'b000010000,
    S_DUP    = 9'b000100000,
    S_DUPCHK = 9'b001000000,
    S_SHIFT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t  st_r;
  cmd_t    c_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, idx_r, slot_r;
  logic          shw_r;

  // ram signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  scsi_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic nr, inb, gt, le;
  assign nr  = c_r.ent.nearest;
  assign inb = c_r.ent.in_box;
  assign gt  = c_r.ent.dist_sq > rdata.dist_sq;
  assign le  = !gt;

  assign cmd_pop   = (st_r == S_IDLE) && cmd_valid;
  assign out_valid = (st_r == S_OUT);

  // result register
  logic          acc_r;
  logic [1:0]    sts_r;
  logic [CW-1:0] pos_r;
  assign out_accepted    = acc_r;
  assign out_status      = sts_r;
  assign out_position    = 6'(pos_r);
  assign out_entry_count = 7'(cnt_r);

  // read address per state; the shift writes one entry per cycle after priming
  always_comb begin
    raddr = AW'(idx_r);
    we    = 1'b0;
    waddr = AW'(idx_r);
    wdata = rdata;
    if (st_r == S_SHIFT) begin
      raddr = AW'(idx_r - CW'(2));
      if (shw_r && (idx_r != cnt_r + CW'(1))) begin
        we = 1'b1;
        if (idx_r == slot_r) begin
          wdata = c_r.ent;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            c_r   <= cmd;
            acc_r <= 1'b0;
            pos_r <= '0;
            idx_r <= cnt_r - CW'(1);
            if (cmd.op == OP_CLEAR) begin
              cnt_r <= '0;
              sts_r <= ST_CLEARED;
              st_r  <= S_OUT;
            end else begin
              st_r <= S_LAST;
            end
          end
        end
        S_LAST: begin
          // read of last entry issued; next read is the first entry
          idx_r  <= '0;
          slot_r <= '0;
          st_r   <= (cnt_r == '0) ? S_DUP : S_FIRST;
        end
        S_FIRST: begin
          // rdata = last entry
          if (gt && (!inb || nr || !rdata.nearest)) begin
            slot_r <= cnt_r;
            idx_r  <= cnt_r;
            st_r   <= S_DUP;
          end else begin
            st_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          // rdata = first entry
          lo_r  <= '0;
          hi_r  <= cnt_r - CW'(1);
          shw_r <= 1'b0;
          if ((le && (!nr || rdata.nearest || !rdata.in_box)) ||
              (inb && !nr && rdata.nearest)) begin
            slot_r <= '0;
            idx_r  <= '0;
            st_r   <= S_DUP;
          end else if (cnt_r - CW'(1) <= CW'(1)) begin
            slot_r <= cnt_r - CW'(1);
            idx_r  <= cnt_r - CW'(1);
            st_r   <= S_DUP;
          end else begin
            idx_r <= CW'((CW+1)'(cnt_r - CW'(1)) >> 1);
            st_r  <= S_BIN;
          end
        end
        S_BIN: begin
          // shw_r low: read issued, wait; high: rdata valid for mid
          if (!shw_r) begin
            shw_r <= 1'b1;
          end else begin
            shw_r <= 1'b0;
            if ((gt && (!inb || nr || !rdata.nearest)) ||
                (nr && !rdata.nearest && inb && rdata.in_box)) begin
              if (hi_r - idx_r <= CW'(1)) begin
                slot_r <= hi_r; idx_r <= hi_r; st_r <= S_DUP;
              end else begin
                lo_r <= idx_r;
                idx_r <= CW'(((CW+1)'(idx_r) + (CW+1)'(hi_r)) >> 1);
              end
            end else begin
              if (idx_r - lo_r <= CW'(1)) begin
                slot_r <= idx_r; st_r <= S_DUP;
              end else begin
                hi_r <= idx_r;
                idx_r <= CW'(((CW+1)'(lo_r) + (CW+1)'(idx_r)) >> 1);
              end
            end
          end
        end
        S_DUP: begin
          // read of idx_r issued
          shw_r <= 1'b0;
          st_r  <= (idx_r >= cnt_r) ? S_SHIFT : S_DUPCHK;
        end
        S_DUPCHK: begin
          if (rdata.dist_sq != c_r.ent.dist_sq) begin
            st_r <= S_SHIFT;
          end else if (rdata.wx == c_r.ent.wx && rdata.wy == c_r.ent.wy &&
                       rdata.wz == c_r.ent.wz) begin
            sts_r <= ST_DUPLICATE;
            st_r  <= S_OUT;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r  <= S_DUP;
          end
        end
        S_SHIFT: begin
          if (!shw_r) begin
            if (cnt_r >= CW'(Capacity)) begin
              sts_r <= ST_FULL;
              st_r  <= S_OUT;
            end else begin
              // first read: entry cnt-1 at address idx-2 with idx=cnt+1
              idx_r <= cnt_r + CW'(1);
              shw_r <= 1'b1;
            end
          end else if (idx_r == cnt_r + CW'(1)) begin
            // priming cycle, no write yet
            idx_r <= cnt_r;
          end else if (idx_r == slot_r) begin
            cnt_r <= cnt_r + CW'(1);
            acc_r <= 1'b1;
            sts_r <= ST_INSERTED;
            pos_r <= slot_r;
            st_r  <= S_OUT;
          end else begin
            idx_r <= idx_r - CW'(1);
          end
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### src/snap_candidate_sorted_insert.sv
// ----------------------------------------------------------------------------
// snap_candidate_sorted_insert
// bounded list of snap candidates kept sorted by squared cursor distance
// ----------------------------------------------------------------------------
// One word at a time: a clear passes the front stages and the queue, then the
// back resets the entry count and reports; an insert passes the front, then
// the back runs the end tests, the binary search probes, the duplicate scan
// steps and, unless the list is full, a shift that moves each entry from the
// last down to the slot up by one and writes the new entry there. Probe and
// scan steps each issue a read and wait, because the entry ram is read with
// registered data. The front takes the next word once the queue is empty,
// one word ahead of the back. No clearing pass is needed.
module snap_candidate_sorted_insert #(
  parameter int CAPACITY = scsi_pkg::DefCapacity
) (
  input  logic clk,
  input  logic rst_n,
  scsi_stream_if.sink   in_if,
  scsi_stream_if.source out_if,
  scsi_stream_if.sink   cfg_if
);
  import scsi_pkg::*;

  // configuration registers
  logic signed [CoordW-1:0] cfg_r [6];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_r[i] <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.idx)
        REG_CURSOR_X, REG_CURSOR_Y, REG_BOX_MIN_X,
        REG_BOX_MAX_X, REG_BOX_MIN_Y, REG_BOX_MAX_Y:
          cfg_r[cfg_if.data.idx] <= cfg_if.data.value;
        default: ;
      endcase
    end
  end

  logic q_push, q_space, q_valid, q_pop;
  cmd_t q_in, q_out;

  scsi_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_op(in_if.data.op), .in_mode(in_if.data.mode_id),
    .in_nearest(in_if.data.is_nearest),
    .in_wx(in_if.data.world_x), .in_wy(in_if.data.world_y),
    .in_wz(in_if.data.world_z),
    .in_sx(in_if.data.screen_x), .in_sy(in_if.data.screen_y),
    .cur_x(cfg_r[REG_CURSOR_X]), .cur_y(cfg_r[REG_CURSOR_Y]),
    .bx0(cfg_r[REG_BOX_MIN_X]), .bx1(cfg_r[REG_BOX_MAX_X]),
    .by0(cfg_r[REG_BOX_MIN_Y]), .by1(cfg_r[REG_BOX_MAX_Y]),
    .q_push(q_push), .q_data(q_in), .q_space(q_space)
  );

  scsi_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .space(q_space),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  scsi_back #(.Capacity(CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_pop(q_pop), .cmd(q_out),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_accepted(out_if.data.accepted), .out_status(out_if.data.status),
    .out_position(out_if.data.position), .out_entry_count(out_if.data.entry_count)
  );
endmodule
